### hdl/usv_pkg.sv
// types, constants and the arctangent table of the uv sphere vertex generator
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
package usv_pkg;

  localparam int DIV_W  = 41;   // dividend and quotient width of the angle dividers
  localparam int REM_W  = 9;    // divider remainder width
  localparam int TAB_LEN = 24;

  localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;

  localparam logic [1:0] REG_RADIUS  = 2'd0;
  localparam logic [1:0] REG_COLOR   = 2'd1;
  localparam logic [1:0] REG_SEGMENT = 2'd2;
  localparam logic [1:0] REG_RING    = 2'd3;

  typedef struct packed {
    logic [15:0] base_index;
    logic        quad_valid;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0] rem_ph;
    logic [DIV_W-1:0] work_ph;
    logic [REM_W-1:0] rem_th;
    logic [DIV_W-1:0] work_th;
    side_t            side;
  } div_t;

  typedef struct packed {
    logic signed [31:0] xt;
    logic signed [31:0] yt;
    logic signed [32:0] zt;
    logic [1:0]         qt;
    logic signed [31:0] xp;
    logic signed [31:0] yp;
    logic signed [32:0] zp;
    logic [1:0]         qp;
    logic [31:0]        u_raw;
    logic [15:0]        tex_v;
    side_t              side;
  } cordic_t;

  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [15:0] normal_x;
    logic [15:0] normal_y;
    logic [15:0] normal_z;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
    logic [15:0] base_index;
    logic        quad_valid;
  } vertex_t;

  // arctangent of 2^-k in 2^-32 turn units
  function automatic logic signed [32:0] atan_turn(input int k);
    logic [31:0] v;
    case (k)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return $signed({1'b0, v});
  endfunction

endpackage

### hdl/usv_div_cell.sv
// one restoring-division step for the phi and theta angle dividers
// depends on usv_pkg
`timescale 1ns / 1ps
module usv_div_cell import usv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [REM_W-1:0] d_ph,
  input  logic [REM_W-1:0] d_th,
  input  logic             up_valid,
  output logic             up_ready,
  input  div_t             up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output div_t             dn_data
);

  logic valid_r;
  div_t data_r, data_nxt;
  logic [REM_W:0] t_ph, t_th;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    data_nxt = up_data;
    t_ph = {up_data.rem_ph, up_data.work_ph[DIV_W-1]};
    t_th = {up_data.rem_th, up_data.work_th[DIV_W-1]};
    if (t_ph >= {1'b0, d_ph}) begin
      data_nxt.rem_ph  = REM_W'(t_ph - {1'b0, d_ph});
      data_nxt.work_ph = {up_data.work_ph[DIV_W-2:0], 1'b1};
    end else begin
      data_nxt.rem_ph  = t_ph[REM_W-1:0];
      data_nxt.work_ph = {up_data.work_ph[DIV_W-2:0], 1'b0};
    end
    if (t_th >= {1'b0, d_th}) begin
      data_nxt.rem_th  = REM_W'(t_th - {1'b0, d_th});
      data_nxt.work_th = {up_data.work_th[DIV_W-2:0], 1'b1};
    end else begin
      data_nxt.rem_th  = t_th[REM_W-1:0];
      data_nxt.work_th = {up_data.work_th[DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

### hdl/usv_cordic_cell.sv
// one rotation step of the theta and phi cordic lanes
// depends on usv_pkg
`timescale 1ns / 1ps
module usv_cordic_cell import usv_pkg::*; #(
  parameter int K = 0
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    up_valid,
  output logic    up_ready,
  input  cordic_t up_data,
  output logic    dn_valid,
  input  logic    dn_ready,
  output cordic_t dn_data
);

  localparam logic signed [32:0] ATAN = atan_turn(K);

  logic    valid_r;
  cordic_t data_r, data_nxt;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    data_nxt = up_data;
    if (!up_data.zt[32]) begin
      data_nxt.xt = up_data.xt - (up_data.yt >>> K);
      data_nxt.yt = up_data.yt + (up_data.xt >>> K);
      data_nxt.zt = up_data.zt - ATAN;
    end else begin
      data_nxt.xt = up_data.xt + (up_data.yt >>> K);
      data_nxt.yt = up_data.yt - (up_data.xt >>> K);
      data_nxt.zt = up_data.zt + ATAN;
    end
    if (!up_data.zp[32]) begin
      data_nxt.xp = up_data.xp - (up_data.yp >>> K);
      data_nxt.yp = up_data.yp + (up_data.xp >>> K);
      data_nxt.zp = up_data.zp - ATAN;
    end else begin
      data_nxt.xp = up_data.xp + (up_data.yp >>> K);
      data_nxt.yp = up_data.yp - (up_data.xp >>> K);
      data_nxt.zp = up_data.zp + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

### hdl/usv_vertex_out.sv
// five-stage back end: quadrant map, products, rounding, radius scaling
// depends on usv_pkg
`timescale 1ns / 1ps
module usv_vertex_out import usv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [14:0] radius,
  input  logic        up_valid,
  output logic        up_ready,
  input  cordic_t     up_data,
  output logic        dn_valid,
  input  logic        dn_ready,
  output vertex_t     dn_data
);

  logic [4:0] v_r;
  logic [4:0] rdy;

  // stage a: quadrant mapped sines and cosines
  logic signed [31:0] ct_r, st_r, cp_r, sp_r;
  logic signed [31:0] ct_nxt, st_nxt, cp_nxt, sp_nxt;
  logic [31:0] ua_r;
  logic [15:0] tva_r;
  side_t sa_r;
  // stage b: products
  logic signed [63:0] pr0_r, pr1_r;
  logic signed [15:0] nzb_r, nz_nxt;
  logic [31:0] ub_r;
  logic [15:0] tvb_r;
  side_t sb_r;
  // stage c: normals and u
  logic signed [15:0] n0_r, n1_r, n2_r, n0_nxt, n1_nxt;
  logic [15:0] tu_r, tu_nxt, tvc_r;
  side_t sc_r;
  // stage d: radius products
  logic signed [31:0] m0_r, m1_r, m2_r;
  logic [15:0] n0d_r, n1d_r, n2d_r, tud_r, tvd_r;
  side_t sd_r;
  // stage e: output
  vertex_t out_r;
  logic [15:0] p0_nxt, p1_nxt, p2_nxt;
  logic signed [15:0] rad_s;

  function automatic logic signed [15:0] norm_round(input logic signed [63:0] p);
    logic signed [64:0] t;
    logic signed [64:0] sh;
    t  = $signed({p[63], p}) + (65'sd1 <<< 45);
    sh = t >>> 46;
    if (sh > 65'sd16384) return 16'sd16384;
    if (sh < -65'sd16384) return -16'sd16384;
    return sh[15:0];
  endfunction

  function automatic logic [15:0] pos_round(input logic signed [31:0] m);
    logic signed [32:0] t;
    logic signed [32:0] sh;
    t  = $signed({m[31], m}) + 33'sd8192;
    sh = t >>> 14;
    if (sh > 33'sd32767) return 16'h7FFF;
    if (sh < -33'sd32768) return 16'h8000;
    return sh[15:0];
  endfunction

  assign rdy[4]   = !v_r[4] || dn_ready;
  assign rdy[3]   = !v_r[3] || rdy[4];
  assign rdy[2]   = !v_r[2] || rdy[3];
  assign rdy[1]   = !v_r[1] || rdy[2];
  assign rdy[0]   = !v_r[0] || rdy[1];
  assign up_ready = rdy[0];
  assign dn_valid = v_r[4];
  assign dn_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= up_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
      if (rdy[3]) v_r[3] <= v_r[2];
      if (rdy[4]) v_r[4] <= v_r[3];
    end
  end

  always_comb begin
    case (up_data.qt)
      2'd0: begin ct_nxt = up_data.xt;  st_nxt = up_data.yt;  end
      2'd1: begin ct_nxt = -up_data.yt; st_nxt = up_data.xt;  end
      2'd2: begin ct_nxt = -up_data.xt; st_nxt = -up_data.yt; end
      default: begin ct_nxt = up_data.yt; st_nxt = -up_data.xt; end
    endcase
    case (up_data.qp)
      2'd0: begin cp_nxt = up_data.xp;  sp_nxt = up_data.yp;  end
      2'd1: begin cp_nxt = -up_data.yp; sp_nxt = up_data.xp;  end
      2'd2: begin cp_nxt = -up_data.xp; sp_nxt = -up_data.yp; end
      default: begin cp_nxt = up_data.yp; sp_nxt = -up_data.xp; end
    endcase
  end

  always_comb begin
    logic signed [32:0] t;
    logic signed [32:0] sh;
    t  = $signed({st_r[31], st_r}) + 33'sd32768;
    sh = t >>> 16;
    if (sh > 33'sd16384) nz_nxt = 16'sd16384;
    else if (sh < -33'sd16384) nz_nxt = -16'sd16384;
    else nz_nxt = sh[15:0];
  end

  always_comb begin
    logic [32:0] u;
    logic [33:0] r;
    n0_nxt = norm_round(pr0_r);
    n1_nxt = norm_round(pr1_r);
    // mirror u on the far side, the poles included
    if (n0_nxt <= 16'sd0) u = 33'h1_0000_0000 - {1'b0, ub_r};
    else u = {1'b0, ub_r};
    r = {1'b0, u} + 34'd32768;
    tu_nxt = (|r[33:32]) ? 16'hFFFF : r[31:16];
  end

  assign rad_s  = $signed({1'b0, radius});
  assign p0_nxt = pos_round(m0_r);
  assign p1_nxt = pos_round(m1_r);
  assign p2_nxt = pos_round(m2_r);

  always_ff @(posedge clk) begin
    if (rdy[0] && up_valid) begin
      ct_r <= ct_nxt; st_r <= st_nxt; cp_r <= cp_nxt; sp_r <= sp_nxt;
      ua_r <= up_data.u_raw; tva_r <= up_data.tex_v; sa_r <= up_data.side;
    end
    if (rdy[1] && v_r[0]) begin
      pr0_r <= 64'(ct_r) * 64'(cp_r);
      pr1_r <= 64'(ct_r) * 64'(sp_r);
      nzb_r <= nz_nxt;
      ub_r <= ua_r; tvb_r <= tva_r; sb_r <= sa_r;
    end
    if (rdy[2] && v_r[1]) begin
      n0_r <= n0_nxt; n1_r <= n1_nxt; n2_r <= nzb_r;
      tu_r <= tu_nxt; tvc_r <= tvb_r; sc_r <= sb_r;
    end
    if (rdy[3] && v_r[2]) begin
      m0_r <= 32'(n0_r) * 32'(rad_s);
      m1_r <= 32'(n1_r) * 32'(rad_s);
      m2_r <= 32'(n2_r) * 32'(rad_s);
      n0d_r <= n0_r; n1d_r <= n1_r; n2d_r <= n2_r;
      tud_r <= tu_r; tvd_r <= tvc_r; sd_r <= sc_r;
    end
    if (rdy[4] && v_r[3]) begin
      out_r.pos_x      <= p0_nxt;
      out_r.pos_y      <= p1_nxt;
      out_r.pos_z      <= p2_nxt;
      out_r.normal_x   <= n0d_r;
      out_r.normal_y   <= n1d_r;
      out_r.normal_z   <= n2d_r;
      out_r.tex_u      <= tud_r;
      out_r.tex_v      <= tvd_r;
      out_r.base_index <= sd_r.base_index;
      out_r.quad_valid <= sd_r.quad_valid;
    end
  end

endmodule

### hdl/uv_sphere_vertex_generator.sv
// top level of the uv sphere vertex generator: config registers, divider and cordic chains
// depends on usv_pkg, usv_div_cell, usv_cordic_cell, usv_vertex_out
`timescale 1ns / 1ps
//
// channel   direction  transaction
// in_*      slave      one grid point: ring index, segment index
// out_*     master     one vertex: position, normal, texture, color, index, quad flag
// cfg_*     write      one register write, no handshake
//
// one grid point enters per clock while in_tready is high; the path runs through 41 divider
// cells, CORDIC_STAGES cordic cells and five back-end stages
// every cell holds its own valid bit and moves when the cell ahead is free, so a
// stalled output only blocks once the whole chain is full
// rst_n clears the valid bits and loads the register defaults
module uv_sphere_vertex_generator import usv_pkg::*; #(
  parameter int MAX_RINGS     = 256,
  parameter int MAX_SEGMENTS  = 256,
  parameter int CORDIC_STAGES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,   // ring_index[7:0], segment_index[16:8], zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, tex_u, tex_v (16 each),
  // color (32), base_index (16), quad_valid (1), zero pad
  output logic [183:0] out_tdata,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wr_data
);

  localparam logic [10:0] MAX_S = 11'(MAX_SEGMENTS);
  localparam logic [10:0] MAX_R = 11'(MAX_RINGS);

  // configuration registers
  logic [14:0] radius_r;
  logic [31:0] color_r;
  logic [8:0]  seg_r;
  logic [8:0]  ring_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 15'd256;
      color_r  <= 32'hFFFF_FFFF;
      seg_r    <= 9'd16;
      ring_r   <= 9'd16;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_RADIUS:  radius_r <= cfg_wr_data[14:0];
        REG_COLOR:   color_r  <= cfg_wr_data;
        REG_SEGMENT: seg_r    <= cfg_wr_data[8:0];
        REG_RING:    ring_r   <= cfg_wr_data[8:0];
        default: ;
      endcase
    end
  end

  // effective counts: segments in [1, MAX_SEGMENTS], rings in [2, MAX_RINGS]
  logic [8:0] seg_eff, ring_eff, ring_m1;
  always_comb begin
    if ({2'b0, seg_r} > MAX_S) seg_eff = MAX_S[8:0];
    else if (seg_r == 9'd0) seg_eff = 9'd1;
    else seg_eff = seg_r;
    if ({2'b0, ring_r} > MAX_R) ring_eff = MAX_R[8:0];
    else if (ring_r < 9'd2) ring_eff = 9'd2;
    else ring_eff = ring_r;
  end
  assign ring_m1 = ring_eff - 9'd1;

  // entry: index and quad flag, divider seeds
  logic [7:0]  j_in;
  logic [8:0]  i_in;
  logic [17:0] base_full;
  div_t        div_in;

  assign j_in      = in_tdata[7:0];
  assign i_in      = in_tdata[16:8];
  assign base_full = 18'(j_in) * 18'({1'b0, seg_eff} + 10'd1) + 18'(i_in);

  always_comb begin
    div_in.rem_ph          = '0;
    div_in.work_ph         = {i_in, 32'd0};        // i * 2^32
    div_in.rem_th          = '0;
    div_in.work_th         = {2'b0, j_in, 31'd0};  // j * 2^31
    div_in.side.base_index = base_full[15:0];
    div_in.side.quad_valid = ({1'b0, j_in} < ring_m1) && (i_in < seg_eff);
  end

  // divider chain: one quotient bit per cell
  logic div_v   [DIV_W+1];
  logic div_rdy [DIV_W+1];
  div_t div_d   [DIV_W+1];

  assign div_v[0] = in_tvalid;
  assign div_d[0] = div_in;
  assign in_tready = div_rdy[0];

  for (genvar k = 0; k < DIV_W; k++) begin : g_div
    usv_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .d_ph     (seg_eff),
      .d_th     (ring_m1),
      .up_valid (div_v[k]),
      .up_ready (div_rdy[k]),
      .up_data  (div_d[k]),
      .dn_valid (div_v[k+1]),
      .dn_ready (div_rdy[k+1]),
      .dn_data  (div_d[k+1])
    );
  end

  // angles, tex_v and the unmirrored u from the quotients
  logic [31:0] ph, th;
  logic [25:0] tv_full;
  logic [32:0] u_wide;
  cordic_t     cor_in;

  assign ph      = div_d[DIV_W].work_ph[31:0];
  assign th      = div_d[DIV_W].work_th[31:0] - 32'h4000_0000;
  assign tv_full = div_d[DIV_W].work_th[DIV_W-1:15];

  always_comb begin
    // u = quarter turn minus asin(sin phi), folded by quadrant
    case (ph[31:30])
      2'd0: u_wide = 33'h0_4000_0000 - {1'b0, ph};
      2'd1, 2'd2: u_wide = {1'b0, ph} - 33'h0_4000_0000;
      default: u_wide = 33'h1_4000_0000 - {1'b0, ph};
    endcase
    cor_in.xt    = CORDIC_X0;
    cor_in.yt    = '0;
    cor_in.zt    = $signed({3'b0, th[29:0]});
    cor_in.qt    = th[31:30];
    cor_in.xp    = CORDIC_X0;
    cor_in.yp    = '0;
    cor_in.zp    = $signed({3'b0, ph[29:0]});
    cor_in.qp    = ph[31:30];
    cor_in.u_raw = u_wide[31:0];
    cor_in.tex_v = (|tv_full[25:16]) ? 16'hFFFF : tv_full[15:0];
    cor_in.side  = div_d[DIV_W].side;
  end

  // cordic chain: one rotation per cell, both angles side by side
  logic    cor_v   [CORDIC_STAGES+1];
  logic    cor_rdy [CORDIC_STAGES+1];
  cordic_t cor_d   [CORDIC_STAGES+1];

  assign cor_v[0]       = div_v[DIV_W];
  assign cor_d[0]       = cor_in;
  assign div_rdy[DIV_W] = cor_rdy[0];

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    usv_cordic_cell #(.K(k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cor_v[k]),
      .up_ready (cor_rdy[k]),
      .up_data  (cor_d[k]),
      .dn_valid (cor_v[k+1]),
      .dn_ready (cor_rdy[k+1]),
      .dn_data  (cor_d[k+1])
    );
  end

  // back end and output register
  vertex_t vtx;

  usv_vertex_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .radius   (radius_r),
    .up_valid (cor_v[CORDIC_STAGES]),
    .up_ready (cor_rdy[CORDIC_STAGES]),
    .up_data  (cor_d[CORDIC_STAGES]),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (vtx)
  );

  // user must hold color static while items are in flight (unenforced); read from register
  assign out_tdata = {7'd0, vtx.quad_valid, vtx.base_index, color_r, vtx.tex_v, vtx.tex_u,
                      vtx.normal_z, vtx.normal_y, vtx.normal_x,
                      vtx.pos_z, vtx.pos_y, vtx.pos_x};

endmodule
